FILE: sv/dq_pkg.sv
// Shared types, constants and ring index helpers for the double-ended queue.
package dq_pkg;

  // Queue geometry.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 7;
  localparam int CMD_W   = 3;
  localparam int KIND_W  = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((VALUE_W + TOTAL_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Command codes carried in the low bits of the input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4,
    CMD_COUNT      = 3'd5
  } dq_cmd_e;

  // Result kinds carried in tuser of the output transfer.
  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_REJECT = 2'd2
  } dq_kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP_READ,
    ST_DUMP_SEND,
    ST_RESULT
  } dq_state_e;

  // Request from the sequencer to the storage ring.
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    value_t wr_data;
    idx_t   rd_addr;
  } dq_mem_req_t;

  // Step one slot forward around the ring.
  function automatic idx_t ring_next(idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  // Step one slot backward around the ring.
  function automatic idx_t ring_prev(idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: sv/dq_ring.sv
// Entry storage of the queue: one write port and one registered read port.
module dq_ring (
  input  logic                clk,
  input  dq_pkg::dq_mem_req_t req,
  output dq_pkg::value_t      rd_data
);
  import dq_pkg::*;

  value_t mem [DEPTH];

  // Write the pushed value and read the requested slot every cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: sv/dq_ctrl.sv
// Command sequencer: ring indices, occupancy, dump walk and result register.
module dq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dq_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dq_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [dq_pkg::KIND_W-1:0]    m_tuser,
  output logic                         m_tlast,
  output dq_pkg::dq_mem_req_t          mem_req,
  input  dq_pkg::value_t               rd_data
);
  import dq_pkg::*;

  dq_state_e state, state_next;
  idx_t      front_index, front_index_next;
  idx_t      back_index, back_index_next;
  cnt_t      occupancy, occupancy_next;
  idx_t      dump_slot, dump_slot_next;
  cnt_t      dump_cnt, dump_cnt_next;

  // Result register.
  dq_kind_e  out_kind, out_kind_next;
  value_t    out_value, out_value_next;
  cnt_t      out_total, out_total_next;
  logic      out_last, out_last_next;

  logic      in_xfer;
  logic      out_xfer;
  dq_cmd_e   cmd;
  value_t    in_value;
  logic      full;
  logic      empty;
  idx_t      base_front;
  idx_t      base_back;

  assign in_xfer    = s_tvalid && s_tready;
  assign out_xfer   = m_tvalid && m_tready;
  assign cmd        = dq_cmd_e'(s_tdata[CMD_W-1:0]);
  assign in_value   = s_tdata[CMD_W+VALUE_W-1:CMD_W];
  assign full       = (occupancy == cnt_t'(DEPTH));
  assign empty      = (occupancy == '0);
  // An empty queue restarts both indices at slot zero.
  assign base_front = empty ? '0 : front_index;
  assign base_back  = empty ? '0 : back_index;

  // Next state and next register values.
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    back_index_next  = back_index;
    occupancy_next   = occupancy;
    dump_slot_next   = dump_slot;
    dump_cnt_next    = dump_cnt;
    out_kind_next    = out_kind;
    out_value_next   = out_value;
    out_total_next   = out_total;
    out_last_next    = out_last;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                out_kind_next  = KIND_REJECT;
                out_value_next = '0;
                out_total_next = occupancy;
                out_last_next  = 1'b1;
                state_next     = ST_RESULT;
              end else begin
                if (cmd == CMD_PUSH_FRONT) begin
                  front_index_next = ring_prev(base_front);
                  back_index_next  = base_back;
                end else begin
                  front_index_next = base_front;
                  back_index_next  = ring_next(base_back);
                end
                occupancy_next = occupancy + cnt_t'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (!empty) begin
                front_index_next = ring_next(front_index);
                occupancy_next   = occupancy - cnt_t'(1);
              end
            end
            CMD_POP_BACK: begin
              if (!empty) begin
                back_index_next = ring_prev(back_index);
                occupancy_next  = occupancy - cnt_t'(1);
              end
            end
            CMD_DUMP: begin
              if (!empty) begin
                dump_slot_next = front_index;
                dump_cnt_next  = '0;
                state_next     = ST_DUMP_READ;
              end
            end
            CMD_COUNT: begin
              out_kind_next  = KIND_COUNT;
              out_value_next = '0;
              out_total_next = occupancy;
              out_last_next  = 1'b1;
              state_next     = ST_RESULT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP_READ: begin
        // Read data for dump_slot has arrived from the ring.
        out_kind_next  = KIND_ENTRY;
        out_value_next = rd_data;
        out_total_next = occupancy;
        out_last_next  = (dump_cnt + cnt_t'(1)) == occupancy;
        state_next     = ST_DUMP_SEND;
      end
      ST_DUMP_SEND: begin
        if (out_xfer) begin
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            dump_slot_next = ring_next(dump_slot);
            dump_cnt_next  = dump_cnt + cnt_t'(1);
            state_next     = ST_DUMP_READ;
          end
        end
      end
      ST_RESULT: begin
        if (out_xfer) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake, ring request and output payload.
  always_comb begin
    s_tready        = (state == ST_IDLE);
    m_tvalid        = (state == ST_DUMP_SEND) || (state == ST_RESULT);
    m_tuser         = out_kind;
    m_tlast         = out_last;
    m_tdata         = '0;
    m_tdata[VALUE_W-1:0]                 = out_value;
    m_tdata[VALUE_W+TOTAL_W-1:VALUE_W]   = TOTAL_W'(out_total);
    mem_req.wr_en   = in_xfer && !full &&
                      ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK));
    mem_req.wr_addr = (cmd == CMD_PUSH_FRONT) ? ring_prev(base_front) : base_back;
    mem_req.wr_data = in_value;
    // The read issued here is consumed in the following dump read state.
    mem_req.rd_addr = (state == ST_IDLE) ? front_index : ring_next(dump_slot);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      back_index  <= '0;
      occupancy   <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      back_index  <= back_index_next;
      occupancy   <= occupancy_next;
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk) begin
    dump_slot <= dump_slot_next;
    dump_cnt  <= dump_cnt_next;
    out_kind  <= out_kind_next;
    out_value <= out_value_next;
    out_total <= out_total_next;
    out_last  <= out_last_next;
  end

  // The queue never holds more than its depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= cnt_t'(DEPTH))
    else $error("occupancy exceeds depth");

  // A result on the output side blocks new commands.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

  // The final result of a command returns the sequencer to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after the final result");

  // An accepted push into a non-full queue grows it by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !full && ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK)))
    |=> (occupancy == $past(occupancy) + cnt_t'(1)))
    else $error("push did not grow the queue");

  // The dump walk never passes the held entries.
  a_dump_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DUMP_READ) || (state == ST_DUMP_SEND)) |-> (dump_cnt < occupancy))
    else $error("dump walked past the held entries");

endmodule

FILE: sv/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tdata: cmd[2:0], value[34:3]
//  m_*      out        m_tvalid/m_tready  tdata: entry_value[31:0],
//                                         entry_total[38:32]; tuser: kind; tlast
//
// Push, pop and count commands are taken in the idle state of the sequencer;
// count and a rejected push then hold one result until it is taken.
// Dump walks the held entries in order: the dump read state takes the
// registered ring read, the dump send state presents the entry until taken.
// No new command is taken while a result is pending or a dump is walking.
// Synchronous reset empties the queue; stored values are not cleared.
module double_ended_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dq_pkg::S_DATA_W-1:0]  s_tdata,   // cmd, value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dq_pkg::M_DATA_W-1:0]  m_tdata,   // entry_value, entry_total
  output logic [dq_pkg::KIND_W-1:0]    m_tuser,   // kind
  output logic                         m_tlast
);
  import dq_pkg::*;

  dq_mem_req_t mem_req;
  value_t      rd_data;

  // Command sequencer.
  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  // Entry storage.
  dq_ring u_ring (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

FILE: bench/tb_double_ended_queue.sv
// Self-checking testbench for the bounded double-ended queue: command table, random mix.
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import dq_pkg::*;

  // Command codes the block does not define; it must ignore them.
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 10;
  localparam int TABLE_ROWS   = 24;

  // One result transfer as seen on the output stream.
  typedef struct packed {
    dq_kind_e            kind;
    value_t              value;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } dq_result_t;

  // One directed command; typed rows carry their single result written out.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    value_t           value;
    logic             typed;
    dq_result_t       result;
  } dq_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;    // cmd, value
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;    // entry_value, entry_total
  logic [KIND_W-1:0]    m_tuser;    // kind
  logic                 m_tlast;

  // Shadow copy of the queue contents.
  value_t ring [DEPTH];
  idx_t   head_slot;
  idx_t   tail_slot;
  cnt_t   held;

  dq_result_t pending_results [$];
  dq_result_t step_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int rejected_pushes;
  int failures;
  int cycle_count;

  dq_row_t command_table [0:TABLE_ROWS-1] = '{
    '{CMD_COUNT,       32'h0000_0000, 1'b1, '{KIND_COUNT, 32'd0, 7'd0, 1'b1}},
    '{CMD_DUMP,        32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, '0},
    '{CMD_UNUSED_6,    32'h1234_5678, 1'b0, '0},
    '{CMD_UNUSED_7,    32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_PUSH_BACK,   32'h7FFF_FFFF, 1'b0, '0},
    '{CMD_PUSH_FRONT,  32'h8000_0000, 1'b0, '0},
    '{CMD_PUSH_BACK,   32'h0000_0000, 1'b0, '0},
    '{CMD_PUSH_FRONT,  32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_COUNT,       32'hFFFF_FFFF, 1'b1, '{KIND_COUNT, 32'd0, 7'd4, 1'b1}},
    '{CMD_DUMP,        32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, '0},
    '{CMD_DUMP,        32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, '0},
    '{CMD_DUMP,        32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, '0},
    '{CMD_COUNT,       32'h0000_0000, 1'b1, '{KIND_COUNT, 32'd0, 7'd0, 1'b1}},
    '{CMD_PUSH_FRONT,  32'h5555_5555, 1'b0, '0},
    '{CMD_PUSH_BACK,   32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_DUMP,        32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,    32'h0000_0000, 1'b0, '0}
  };

  double_ended_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run the command through the shadow queue and collect the results it causes.
  task automatic predict_command(input logic [CMD_W-1:0] cmd, input value_t val);
    idx_t slot;
    int   i;
    step_results.delete();
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held >= DEPTH) begin
          step_results.push_back('{KIND_REJECT, value_t'(0), held, 1'b1});
          rejected_pushes++;
        end else begin
          // An empty queue restarts at slot zero.
          if (held == 0) begin
            head_slot = '0;
            tail_slot = '0;
          end
          if (cmd == CMD_PUSH_FRONT) begin
            head_slot = idx_t'((int'(head_slot) + DEPTH - 1) % DEPTH);
            ring[head_slot] = val;
          end else begin
            ring[tail_slot] = val;
            tail_slot = idx_t'((int'(tail_slot) + 1) % DEPTH);
          end
          held++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        // A pop on an empty queue is ignored.
        if (held != 0) begin
          if (cmd == CMD_POP_FRONT) begin
            head_slot = idx_t'((int'(head_slot) + 1) % DEPTH);
          end else begin
            tail_slot = idx_t'((int'(tail_slot) + DEPTH - 1) % DEPTH);
          end
          held--;
        end
      end
      CMD_DUMP: begin
        slot = head_slot;
        for (i = 0; i < int'(held); i++) begin
          step_results.push_back('{KIND_ENTRY, ring[slot], held, (i + 1 == int'(held))});
          slot = idx_t'((int'(slot) + 1) % DEPTH);
        end
      end
      CMD_COUNT: begin
        step_results.push_back('{KIND_COUNT, value_t'(0), held, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  // Offer one command, wait for its transfer, then record what it should produce.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input value_t val,
                               input logic typed, input dq_result_t typed_result);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - CMD_W - VALUE_W){1'b0}}, val, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(cmd, val);
    if (typed) begin
      pending_results.push_back(typed_result);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  // Draw a command whose mix depends on the phase: fill, drain, or mixed.
  function automatic logic [CMD_W-1:0] pick_command(input int phase);
    int pick;
    int cut [6];
    pick = $urandom_range(99);
    if (phase == 0) begin
      cut = '{47, 94, 95, 96, 98, 99};
    end else if (phase == 1) begin
      cut = '{10, 20, 50, 80, 88, 95};
    end else begin
      cut = '{25, 50, 65, 80, 88, 96};
    end
    if (pick < cut[0]) return CMD_PUSH_FRONT;
    if (pick < cut[1]) return CMD_PUSH_BACK;
    if (pick < cut[2]) return CMD_POP_FRONT;
    if (pick < cut[3]) return CMD_POP_BACK;
    if (pick < cut[4]) return CMD_DUMP;
    if (pick < cut[5]) return CMD_COUNT;
    return pick[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;
  endfunction

  // Mostly full-range values, with the corners mixed in now and then.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return value_t'($urandom());
    endcase
  endfunction

  // Receiver backpressure, changed only at the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every output transfer with the oldest expected result.
  always @(posedge clk) begin : check_results
    dq_result_t got;
    dq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{dq_kind_e'(m_tuser), m_tdata[VALUE_W-1:0],
              m_tdata[VALUE_W +: TOTAL_W], m_tlast};
      if (pending_results.size() == 0) begin
        if (failures < REPORT_LIMIT) begin
          $display("%0t: unexpected result kind=%0d value=%0d total=%0d last=%0b",
                   $realtime, got.kind, $signed(got.value), got.total, got.last);
        end
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.total !== want.total || got.last !== want.last) begin
          if (failures < REPORT_LIMIT) begin
            $display("%0t: mismatch expected kind=%0d value=%0d total=%0d last=%0b",
                     $realtime, want.kind, $signed(want.value), want.total, want.last);
            $display("%0t:          actual   kind=%0d value=%0d total=%0d last=%0b",
                     $realtime, got.kind, $signed(got.value), got.total, got.last);
          end
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed table, then fill, drain and mixed random phases.
  initial begin : stimulus
    int n;
    int phase;
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    held            = '0;
    head_slot       = '0;
    tail_slot       = '0;
    failures        = 0;
    cycle_count     = 0;
    rejected_pushes = 0;
    send_idle_pct   = 37;
    recv_idle_pct   = 56;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (n = 0; n < TABLE_ROWS; n++) begin
      issue_command(command_table[n].cmd, command_table[n].value,
                    command_table[n].typed, command_table[n].result);
    end

    for (phase = 0; phase < 3; phase++) begin
      // Idle pattern: sender light and receiver heavy, then swapped, then none.
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 37 : 0;
      n = 0;
      // The fill phase runs until the full queue has turned pushes away.
      while (n < 150 &&
             ((phase == 0 && (n < 20 || rejected_pushes < 2)) ||
              (phase != 0 && n < 8))) begin
        issue_command(pick_command(phase), pick_value(), 1'b0, '0);
        n++;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for strays over a full dump's latency.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 16) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
